// ===== design/dsl_pkg.sv =====
`default_nettype none

package dsl_pkg;

	// phase accumulator width and quarter-wave table size
	localparam int PHASE_BITS_DEF = 32;
	localparam int QUARTER_STEPS = 32;

	// field and register widths
	localparam int MS_W = 10;
	localparam int CFG_W = 16;
	localparam int RANGE_W = 8;
	localparam int DELAY_W = 16;
	localparam int MAG_W = 7;
	localparam int OUT_W = 25;
	localparam int STEP_P_W = CFG_W + MS_W;
	localparam int PROD1_W = MAG_W + CFG_W;
	localparam int PROD2_W = PROD1_W + RANGE_W;
	localparam int REM_W = 10;

	// register indexes
	localparam logic [1:0] REG_DEPTH = 2'd0;
	localparam logic [1:0] REG_RANGE = 2'd1;
	localparam logic [1:0] REG_SPEED = 2'd2;
	localparam logic [1:0] REG_DELAY = 2'd3;

	// register reset values
	localparam logic [CFG_W-1:0] DEPTH_RST = 16'd0;
	localparam logic [RANGE_W-1:0] RANGE_RST = 8'd1;
	localparam logic [CFG_W-1:0] SPEED_RST = 16'd1600;
	localparam logic [DELAY_W-1:0] DELAY_RST = 16'd0;

	// divisors: ms per second, and twice 127 for round to nearest
	localparam logic [REM_W-1:0] DIV_PHASE = 10'd1000;
	localparam logic [REM_W-1:0] DIV_OUT = 10'd254;
	localparam int OUT_BIAS = 127;

	typedef struct packed {
		logic start;
		logic sel_out;
	} div_req_t;

	// quarter-wave sine, 7-bit magnitude, entries 0..QUARTER_STEPS
	function automatic logic [MAG_W-1:0] quarter_sine(input logic [5:0] idx);
		logic [MAG_W-1:0] m;
		case (idx)
			6'd0: m = 7'h00;
			6'd1: m = 7'h06;
			6'd2: m = 7'h0C;
			6'd3: m = 7'h13;
			6'd4: m = 7'h19;
			6'd5: m = 7'h1F;
			6'd6: m = 7'h25;
			6'd7: m = 7'h2B;
			6'd8: m = 7'h31;
			6'd9: m = 7'h36;
			6'd10: m = 7'h3C;
			6'd11: m = 7'h41;
			6'd12: m = 7'h47;
			6'd13: m = 7'h4C;
			6'd14: m = 7'h51;
			6'd15: m = 7'h55;
			6'd16: m = 7'h5A;
			6'd17: m = 7'h5E;
			6'd18: m = 7'h62;
			6'd19: m = 7'h66;
			6'd20: m = 7'h6A;
			6'd21: m = 7'h6D;
			6'd22: m = 7'h70;
			6'd23: m = 7'h73;
			6'd24: m = 7'h75;
			6'd25: m = 7'h78;
			6'd26: m = 7'h7A;
			6'd27: m = 7'h7B;
			6'd28: m = 7'h7D;
			6'd29: m = 7'h7E;
			6'd30: m = 7'h7E;
			6'd31: m = 7'h7F;
			6'd32: m = 7'h7F;
			default: m = 7'h00;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/delayed_sine_lfo_top.sv =====
// words are accepted only in idle, so a new word waits until the previous result moves to the output
// register; processing time is set by up to two passes through the shared radix-4 serial divider
// (phase step, then output rounding): the phase step pass is skipped while the delay holds the phase
// and the rounding pass when the output is forced to zero, and processing is longer while out_ready
// holds back the previous word; a new word is taken while a result waits in the output
// reset: async active low, clears phase, delay counter and control; registers to defaults
`default_nettype none

module delayed_sine_lfo_top import dsl_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [MS_W-1:0] elapsed_ms,
	input wire logic restart,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [OUT_W-1:0] lfo_value,
	input wire logic cfg_wr_en,
	input wire logic [1:0] cfg_addr,
	input wire logic [CFG_W-1:0] cfg_wdata
);

	// divider width: phase step dividend is speed*ms shifted up by PHASE_BITS-8,
	// rounded up to an even count for two bits per cycle
	localparam int DIV_W = ((PHASE_BITS + 19) / 2) * 2;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL = 4'd1;   // speed * ms
	localparam logic [3:0] ST_LDP = 4'd2;   // start phase step division
	localparam logic [3:0] ST_DIVP = 4'd3;  // wait, then add step to phase
	localparam logic [3:0] ST_SIN1 = 4'd4;  // table * depth
	localparam logic [3:0] ST_SIN2 = 4'd5;  // * range
	localparam logic [3:0] ST_LDO = 4'd6;   // start rounding division by 127
	localparam logic [3:0] ST_DIVO = 4'd7;  // wait, then apply sign
	localparam logic [3:0] ST_FIN = 4'd8;   // hand result to output register

	logic [3:0] state_q;

	// configuration registers
	logic [CFG_W-1:0] depth_q;
	logic [RANGE_W-1:0] range_q;
	logic [CFG_W-1:0] speed_q;
	logic [DELAY_W-1:0] delay_q;

	// oscillator state
	logic [PHASE_BITS-1:0] phase_q;
	logic [DELAY_W-1:0] delay_el_q;

	// per-word work registers
	logic [MS_W-1:0] ms_q;
	logic adv_q;
	logic zero_q;
	logic [STEP_P_W-1:0] p_q;
	logic signed [OUT_W-1:0] res_q;

	// output register
	logic out_valid_q;
	logic signed [OUT_W-1:0] lfo_value_q;

	logic accept;
	logic [DELAY_W-1:0] de_base;
	logic [DELAY_W:0] de_sum;
	logic running;
	logic [DELAY_W-1:0] de_new;
	logic [MS_W-1:0] ms_new;
	logic adv_new;
	logic zero_new;

	div_req_t div_req;
	logic [DIV_W-1:0] div_dividend;
	logic div_busy;
	logic [DIV_W-1:0] div_quot;

	logic [PROD2_W-1:0] sine_prod;
	logic sine_neg;
	logic [OUT_W-1:0] mag_out;
	logic out_load;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// restart first, then the start delay eats into the elapsed time
	always_comb begin
		de_base = restart ? '0 : delay_el_q;
		running = de_base < delay_q;
		de_sum = {1'b0, de_base} + (DELAY_W + 1)'(elapsed_ms);
		de_new = de_base;
		ms_new = elapsed_ms;
		adv_new = 1'b1;
		if (running) begin
			if (de_sum <= {1'b0, delay_q}) begin
				// still inside the delay: no phase motion
				de_new = de_sum[DELAY_W-1:0];
				adv_new = 1'b0;
			end else begin
				// crossing the end: only the leftover time advances
				de_new = delay_q;
				ms_new = MS_W'(de_sum - {1'b0, delay_q});
			end
		end
		zero_new = (depth_q == '0) || (de_new < delay_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RST;
			range_q <= RANGE_RST;
			speed_q <= SPEED_RST;
			delay_q <= DELAY_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_DEPTH: depth_q <= cfg_wdata;
				REG_RANGE: range_q <= cfg_wdata[RANGE_W-1:0];
				REG_SPEED: speed_q <= cfg_wdata;
				REG_DELAY: delay_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// shared serial divider
	always_comb begin
		div_req.start = (state_q == ST_LDP) || (state_q == ST_LDO);
		div_req.sel_out = (state_q == ST_LDO);
		if (state_q == ST_LDO) begin
			// 2*prod+127 over 254 rounds prod/127 to nearest
			div_dividend = DIV_W'({sine_prod, 1'b0}) + DIV_W'(OUT_BIAS);
		end else begin
			div_dividend = DIV_W'(p_q) << (PHASE_BITS - 8);
		end
	end

	dsl_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.dividend(div_dividend),
		.busy(div_busy),
		.quotient(div_quot)
	);

	// table lookup and scaling, follows the phase register every cycle
	dsl_sine u_sine (
		.clk(clk),
		.idx(phase_q[PHASE_BITS-1 -: MAG_W]),
		.depth(depth_q),
		.range_mult(range_q),
		.prod(sine_prod),
		.neg(sine_neg)
	);

	assign mag_out = div_quot[OUT_W-1:0];
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// sequencer and oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			delay_el_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (restart) begin
							phase_q <= '0;
						end
						delay_el_q <= de_new;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (adv_q) begin
						state_q <= ST_LDP;
					end else if (zero_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SIN1;
					end
				end
				ST_LDP: state_q <= ST_DIVP;
				ST_DIVP: begin
					if (!div_busy) begin
						phase_q <= phase_q + div_quot[PHASE_BITS-1:0];
						state_q <= zero_q ? ST_FIN : ST_SIN1;
					end
				end
				ST_SIN1: state_q <= ST_SIN2;
				ST_SIN2: state_q <= ST_LDO;
				ST_LDO: state_q <= ST_DIVO;
				ST_DIVO: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ms_q <= ms_new;
			adv_q <= adv_new;
			zero_q <= zero_new;
		end
		if (state_q == ST_MUL) begin
			p_q <= STEP_P_W'(speed_q) * STEP_P_W'(ms_q);
			res_q <= '0;
		end
		if (state_q == ST_DIVO && !div_busy) begin
			res_q <= sine_neg ? -$signed(mag_out) : $signed(mag_out);
		end
		if (out_load) begin
			lfo_value_q <= res_q;
		end
	end

	// output register: holds a word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign lfo_value = lfo_value_q;

endmodule

`default_nettype wire

// ===== design/dsl_div.sv =====
`default_nettype none

module dsl_div import dsl_pkg::*; #(
	parameter int DIV_W = 50
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	input wire logic [DIV_W-1:0] dividend,
	output logic busy,
	output logic [DIV_W-1:0] quotient
);

	// restoring division, two quotient bits per cycle
	localparam int STEPS = DIV_W / 2;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dq_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] divisor_q;

	logic [REM_W:0] r_a, r_a2, r_b, r_b2;
	logic ge_a, ge_b;
	logic [DIV_W-1:0] dq_d;

	always_comb begin
		r_a = {rem_q, dq_q[DIV_W-1]};
		ge_a = r_a >= {1'b0, divisor_q};
		r_a2 = ge_a ? r_a - {1'b0, divisor_q} : r_a;
		r_b = {r_a2[REM_W-1:0], dq_q[DIV_W-2]};
		ge_b = r_b >= {1'b0, divisor_q};
		r_b2 = ge_b ? r_b - {1'b0, divisor_q} : r_b;
		dq_d = {dq_q[DIV_W-3:0], ge_a, ge_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q <= dividend;
			rem_q <= '0;
			divisor_q <= req.sel_out ? DIV_OUT : DIV_PHASE;
		end else if (busy_q) begin
			dq_q <= dq_d;
			rem_q <= r_b2[REM_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

// ===== design/dsl_sine.sv =====
`default_nettype none

module dsl_sine import dsl_pkg::*; (
	input wire logic clk,
	input wire logic [MAG_W-1:0] idx,
	input wire logic [CFG_W-1:0] depth,
	input wire logic [RANGE_W-1:0] range_mult,
	output logic [PROD2_W-1:0] prod,
	output logic neg
);

	logic [4:0] low;
	logic [5:0] tidx;
	logic [MAG_W-1:0] mag;
	logic [PROD1_W-1:0] prod_s1;
	logic neg_s1;
	logic [PROD2_W-1:0] prod_s2;
	logic neg_s2;

	// second and fourth quarters read the table backwards
	always_comb begin
		low = idx[4:0];
		tidx = idx[5] ? 6'(QUARTER_STEPS) - {1'b0, low} : {1'b0, low};
		mag = quarter_sine(tidx);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD1_W'(mag) * PROD1_W'(depth);
		neg_s1 <= idx[MAG_W-1];
		prod_s2 <= PROD2_W'(prod_s1) * PROD2_W'(range_mult);
		neg_s2 <= neg_s1;
	end

	assign prod = prod_s2;
	assign neg = neg_s2;

endmodule

`default_nettype wire
